@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the display timing sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that a property holds at every rising edge outside reset.
`define LMLS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition is never true at a rising edge outside reset.
`define LMLS_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LMLS_ASSERT(label, clk, rst_n, prop, msg)
`define LMLS_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/lmls_pkg.sv @@
// Types and constants shared by the display timing sequencer modules.
`timescale 1ns / 1ps
package lmls_pkg;

	localparam int unsigned VISIBLE_LINES_DEF = 144;
	localparam int unsigned LAST_LINE_DEF     = 153;

	localparam int unsigned THR_W   = 10;
	localparam int unsigned LINE_W  = 8;
	localparam int unsigned ACCUM_W = 11;
	localparam int unsigned ELAP_W  = 8;
	localparam int unsigned EN_W    = 4;
	localparam int unsigned IDX_W   = 3;

	localparam logic [ACCUM_W-1:0] ACCUM_MAX = '1;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	localparam logic [IDX_W-1:0] CFG_OAM_CYCLES      = 3'd0;
	localparam logic [IDX_W-1:0] CFG_TRANSFER_CYCLES = 3'd1;
	localparam logic [IDX_W-1:0] CFG_HBLANK_CYCLES   = 3'd2;
	localparam logic [IDX_W-1:0] CFG_VBLANK_CYCLES   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_STAT_ENABLES    = 3'd4;
	localparam logic [IDX_W-1:0] CFG_COMPARE_LINE    = 3'd5;
	localparam logic [IDX_W-1:0] CFG_WINDOW_ENABLE   = 3'd6;

	localparam int unsigned EN_HBLANK  = 0;
	localparam int unsigned EN_VBLANK  = 1;
	localparam int unsigned EN_OAM     = 2;
	localparam int unsigned EN_COMPARE = 3;

	localparam logic [THR_W-1:0] OAM_CYCLES_RST      = 10'd80;
	localparam logic [THR_W-1:0] TRANSFER_CYCLES_RST = 10'd172;
	localparam logic [THR_W-1:0] HBLANK_CYCLES_RST   = 10'd204;
	localparam logic [THR_W-1:0] VBLANK_CYCLES_RST   = 10'd456;

	typedef struct packed {
		logic [THR_W-1:0]  oam_cycles;
		logic [THR_W-1:0]  transfer_cycles;
		logic [THR_W-1:0]  hblank_cycles;
		logic [THR_W-1:0]  vblank_line_cycles;
		logic [EN_W-1:0]   stat_enables;
		logic [LINE_W-1:0] compare_line;
		logic              window_enable;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [LINE_W-1:0] line;
		logic              render_line;
		logic              vblank_irq;
		logic              stat_irq;
		logic [LINE_W-1:0] window_line;
	} result_t;

endpackage

@@ rtl/core/lmls_cfg.sv @@
// Configuration register file of the display timing sequencer.
`timescale 1ns / 1ps
module lmls_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lmls_pkg::IDX_W-1:0] cfg_index,
	input  logic [lmls_pkg::THR_W-1:0] cfg_data,
	output lmls_pkg::cfg_t             cfg
);

	lmls_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.oam_cycles         <= lmls_pkg::OAM_CYCLES_RST;
			cfg_q.transfer_cycles    <= lmls_pkg::TRANSFER_CYCLES_RST;
			cfg_q.hblank_cycles      <= lmls_pkg::HBLANK_CYCLES_RST;
			cfg_q.vblank_line_cycles <= lmls_pkg::VBLANK_CYCLES_RST;
			cfg_q.stat_enables       <= '0;
			cfg_q.compare_line       <= '0;
			cfg_q.window_enable      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lmls_pkg::CFG_OAM_CYCLES:      cfg_q.oam_cycles <= cfg_data;
				lmls_pkg::CFG_TRANSFER_CYCLES: cfg_q.transfer_cycles <= cfg_data;
				lmls_pkg::CFG_HBLANK_CYCLES:   cfg_q.hblank_cycles <= cfg_data;
				lmls_pkg::CFG_VBLANK_CYCLES:   cfg_q.vblank_line_cycles <= cfg_data;
				lmls_pkg::CFG_STAT_ENABLES:
					cfg_q.stat_enables <= cfg_data[lmls_pkg::EN_W-1:0];
				lmls_pkg::CFG_COMPARE_LINE:
					cfg_q.compare_line <= cfg_data[lmls_pkg::LINE_W-1:0];
				lmls_pkg::CFG_WINDOW_ENABLE:   cfg_q.window_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/lmls_timing.sv @@
// Mode and line state of the display timing sequencer and its per-item update.
`timescale 1ns / 1ps
module lmls_timing #(
	parameter int unsigned VISIBLE_LINES = lmls_pkg::VISIBLE_LINES_DEF,
	parameter int unsigned LAST_LINE     = lmls_pkg::LAST_LINE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step_en,
	input  logic [lmls_pkg::ELAP_W-1:0] elapsed,
	input  lmls_pkg::cfg_t              cfg,
	output lmls_pkg::result_t           res
);

	localparam logic [lmls_pkg::LINE_W-1:0] VIS_LINE  = lmls_pkg::LINE_W'(VISIBLE_LINES);
	localparam logic [lmls_pkg::LINE_W-1:0] LAST_LINE_V = lmls_pkg::LINE_W'(LAST_LINE);

	logic [lmls_pkg::ACCUM_W-1:0] accum_q, accum_d, accum_sat, accum_diff;
	logic [lmls_pkg::ACCUM_W:0]   accum_sum;
	lmls_pkg::mode_t              mode_q, mode_d;
	logic [lmls_pkg::LINE_W-1:0]  line_q, line_d, line_inc;
	logic [lmls_pkg::LINE_W-1:0]  win_q, win_d;
	logic [lmls_pkg::THR_W-1:0]   thr;
	logic                         reached, check, render, vbl, hit;

	assign accum_sum  = {1'b0, accum_q} + (lmls_pkg::ACCUM_W + 1)'(elapsed);
	assign accum_sat  = accum_sum[lmls_pkg::ACCUM_W] ? lmls_pkg::ACCUM_MAX
		: accum_sum[lmls_pkg::ACCUM_W-1:0];
	assign reached    = accum_sat >= lmls_pkg::ACCUM_W'(thr);
	assign accum_diff = accum_sat - lmls_pkg::ACCUM_W'(thr);
	assign line_inc   = line_q + 8'd1;

	always_comb begin
		unique case (mode_q)
			lmls_pkg::MODE_OAM:    thr = cfg.oam_cycles;
			lmls_pkg::MODE_XFER:   thr = cfg.transfer_cycles;
			lmls_pkg::MODE_HBLANK: thr = cfg.hblank_cycles;
			default:               thr = cfg.vblank_line_cycles;
		endcase
	end

	always_comb begin
		accum_d = accum_sat;
		mode_d  = mode_q;
		line_d  = line_q;
		win_d   = win_q;
		render  = 1'b0;
		vbl     = 1'b0;
		check   = 1'b0;
		unique case (mode_q)
			lmls_pkg::MODE_OAM: begin
				if (reached) begin
					accum_d = accum_diff;
					mode_d  = lmls_pkg::MODE_XFER;
					check   = 1'b1;
				end
			end
			lmls_pkg::MODE_XFER: begin
				if (reached) begin
					accum_d = accum_diff;
					render  = line_q < VIS_LINE;
					mode_d  = lmls_pkg::MODE_HBLANK;
					check   = 1'b1;
				end
			end
			lmls_pkg::MODE_HBLANK: begin
				if (reached) begin
					accum_d = accum_diff;
					line_d  = line_inc;
					if (cfg.window_enable) begin
						win_d = win_q + 8'd1;
					end
					mode_d = (line_inc == VIS_LINE) ? lmls_pkg::MODE_VBLANK
						: lmls_pkg::MODE_OAM;
					check  = 1'b1;
				end
			end
			default: begin
				vbl   = 1'b1;
				win_d = '0;
				if (reached) begin
					accum_d = accum_diff;
					if (line_q >= LAST_LINE_V) begin
						line_d = '0;
						mode_d = lmls_pkg::MODE_OAM;
						check  = 1'b1;
					end else begin
						line_d = line_inc;
					end
				end
			end
		endcase
	end

	always_comb begin
		hit = (line_d == cfg.compare_line) && cfg.stat_enables[lmls_pkg::EN_COMPARE];
		unique case (mode_d)
			lmls_pkg::MODE_HBLANK: hit = hit || cfg.stat_enables[lmls_pkg::EN_HBLANK];
			lmls_pkg::MODE_VBLANK: hit = hit || cfg.stat_enables[lmls_pkg::EN_VBLANK];
			lmls_pkg::MODE_OAM:    hit = hit || cfg.stat_enables[lmls_pkg::EN_OAM];
			default: ;
		endcase
	end

	always_comb begin
		res.mode        = mode_d;
		res.line        = line_d;
		res.render_line = render;
		res.vblank_irq  = vbl;
		res.stat_irq    = check && hit;
		res.window_line = win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			mode_q  <= lmls_pkg::MODE_OAM;
			line_q  <= '0;
			win_q   <= '0;
		end else if (step_en) begin
			accum_q <= accum_d;
			mode_q  <= mode_d;
			line_q  <= line_d;
			win_q   <= win_d;
		end
	end

endmodule

@@ rtl/core/lcd_mode_line_sequencer_core.sv @@
// Top level of the display timing sequencer: input register, state update and result register.
//
// The input channel carries one transaction per batch of elapsed machine cycles;
// each one yields exactly one result transaction on the output channel with the
// mode, line, render strobe, vertical blank level, status interrupt and window line.
// Both channels use valid and stall; a transaction completes when valid is high
// and stall is low. The configuration channel uses valid and ready and is always
// ready; the user must write it only while no transaction is in flight, and the
// block itself does not enforce this. An accepted transaction sits in the input
// register while the state update feeds the result register.
// Throughput is one transaction per cycle unless stalled; the mode, line, window and cycle
// accumulator registers are updated in the same cycle that the result register
// loads, so each transaction sees the state left by the one before it.
// While the receiver stalls, the result register holds; the input register keeps
// one more transaction and then the input channel is stalled as well.
// Reset clears the pipeline, loads the default timing registers and starts in
// object search on line zero with an empty cycle accumulator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcd_mode_line_sequencer_core #(
	parameter int unsigned VISIBLE_LINES = lmls_pkg::VISIBLE_LINES_DEF,
	parameter int unsigned LAST_LINE     = lmls_pkg::LAST_LINE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lmls_pkg::ELAP_W-1:0] elapsed_cycles,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  mode,
	output logic [lmls_pkg::LINE_W-1:0] line,
	output logic                        render_line,
	output logic                        vblank_irq,
	output logic                        stat_irq,
	output logic [lmls_pkg::LINE_W-1:0] window_line,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lmls_pkg::IDX_W-1:0]  cfg_index,
	input  logic [lmls_pkg::THR_W-1:0]  cfg_data
);

	lmls_pkg::cfg_t               cfg;
	lmls_pkg::result_t            res;
	lmls_pkg::result_t            res_s2;
	logic                         valid_s1, valid_s2;
	logic [lmls_pkg::ELAP_W-1:0]  elapsed_s1;
	logic                         in_accept, step_en;

	lmls_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lmls_timing #(
		.VISIBLE_LINES (VISIBLE_LINES),
		.LAST_LINE     (LAST_LINE)
	) u_timing (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.elapsed (elapsed_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign step_en   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			elapsed_s1 <= elapsed_cycles;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_en) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign mode        = res_s2.mode;
	assign line        = res_s2.line;
	assign render_line = res_s2.render_line;
	assign vblank_irq  = res_s2.vblank_irq;
	assign stat_irq    = res_s2.stat_irq;
	assign window_line = res_s2.window_line;

	`LMLS_ASSERT(a_vblank_exit, clk, arst_n, (valid_s2 && res_s2.vblank_irq) |-> (res_s2.mode == lmls_pkg::MODE_VBLANK || res_s2.mode == lmls_pkg::MODE_OAM), "vertical blank left to a mode other than object search")
	`LMLS_ASSERT(a_vblank_window, clk, arst_n, (valid_s2 && res_s2.vblank_irq) |-> (res_s2.window_line == '0), "window line not cleared in vertical blank")
	`LMLS_ASSERT(a_render_mode, clk, arst_n, (valid_s2 && res_s2.render_line) |-> (res_s2.mode == lmls_pkg::MODE_HBLANK), "render strobe outside the end of pixel transfer")
	`LMLS_NEVER(n_xfer_stat, clk, arst_n, valid_s2 && res_s2.stat_irq && res_s2.mode == lmls_pkg::MODE_XFER && !(cfg.stat_enables[lmls_pkg::EN_COMPARE] && res_s2.line == cfg.compare_line), "status interrupt on transfer entry without a line compare match")
	`LMLS_NEVER(n_stall_loss, clk, arst_n, in_accept && valid_s1 && !step_en, "input register overwritten while holding a transaction")

endmodule
